[design/assert_macros.svh]
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[design/qmn_pkg.sv]
// Shared constants for the quaternion multiply and normalize block.
package qmn_pkg;
    localparam int NUM_LANES = 4;
    localparam int NUM_TERMS = 4;
    localparam int LANE_X    = 0;
    localparam int LANE_Y    = 1;
    localparam int LANE_Z    = 2;
    localparam int LANE_W    = 3;
endpackage

[design/quaternion_multiply_normalize.sv]
// Quaternion Hamilton product with exact renormalization to unit length.
//
// Takes two quaternions A and B (signed Q2.14 at the default COMP_WIDTH of 16)
// and returns P = A*B / |A*B|, each component rounded to nearest (ties away
// from zero) in the same format. When the product is exactly zero, all four
// components are zero and zero_length is set. The block is a fully pipelined
// datapath: it accepts one item every clock unless every stage is full and
// the output is stalled. The depth is set by the normalizing divide, which
// resolves one result bit per stage for all four components in parallel
// (COMP_WIDTH-1 stages), behind seven stages of multiply, sum, magnitude,
// split squaring, length sum and setup. Every stage carries a valid bit and
// loads whenever it is empty or its successor moves, so bubbles close up
// during an output stall and the input only stops taking items when every
// stage holds one and the output is not being taken. There is no state
// between items and no configuration.
`include "assert_macros.svh"

module quaternion_multiply_normalize #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COMP_WIDTH-1:0] a_x,
    input  logic signed [COMP_WIDTH-1:0] a_y,
    input  logic signed [COMP_WIDTH-1:0] a_z,
    input  logic signed [COMP_WIDTH-1:0] a_w,
    input  logic signed [COMP_WIDTH-1:0] b_x,
    input  logic signed [COMP_WIDTH-1:0] b_y,
    input  logic signed [COMP_WIDTH-1:0] b_z,
    input  logic signed [COMP_WIDTH-1:0] b_w,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COMP_WIDTH-1:0] p_x,
    output logic signed [COMP_WIDTH-1:0] p_y,
    output logic signed [COMP_WIDTH-1:0] p_z,
    output logic signed [COMP_WIDTH-1:0] p_w,
    output logic                         zero_length
);

    localparam int W   = COMP_WIDTH;
    localparam int F   = W - 2;           // fraction bits
    localparam int NL  = qmn_pkg::NUM_LANES;
    localparam int NT  = qmn_pkg::NUM_TERMS;
    localparam int PW  = 2 * W;           // one partial product
    localparam int QW  = 2 * W + 2;       // signed product component
    localparam int MW  = 2 * W + 1;       // its magnitude
    localparam int LO  = MW / 2;          // low half for split squaring
    localparam int HI  = MW - LO;
    localparam int SW  = 2 * MW;          // square of one component
    localparam int L2W = 4 * W + 4;       // squared length
    localparam int YW  = 5 * W + 6;       // d * L2 tracker
    localparam int RW  = 6 * W + 6;       // remainder
    localparam int NW  = F + 1;           // result magnitude bits
    localparam int NIT = F + 1;           // divide stages

    // stage map
    localparam int ST_PROD = 0;
    localparam int ST_SUM  = 1;
    localparam int ST_MAG  = 2;
    localparam int ST_PART = 3;
    localparam int ST_SQ   = 4;
    localparam int ST_LEN  = 5;
    localparam int ST_INIT = 6;
    localparam int NS      = ST_INIT + NIT + 2;
    localparam int ST_OUT  = NS - 1;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    // ---------------- flow control ----------------
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[ST_PROD];
    assign out_valid = v_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: partial products ----------------
    logic signed [PW-1:0] prod_reg [NL][NT];

    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            prod_reg[qmn_pkg::LANE_X][0] <= a_w * b_x;
            prod_reg[qmn_pkg::LANE_X][1] <= b_w * a_x;
            prod_reg[qmn_pkg::LANE_X][2] <= a_y * b_z;
            prod_reg[qmn_pkg::LANE_X][3] <= a_z * b_y;
            prod_reg[qmn_pkg::LANE_Y][0] <= a_w * b_y;
            prod_reg[qmn_pkg::LANE_Y][1] <= b_w * a_y;
            prod_reg[qmn_pkg::LANE_Y][2] <= a_z * b_x;
            prod_reg[qmn_pkg::LANE_Y][3] <= a_x * b_z;
            prod_reg[qmn_pkg::LANE_Z][0] <= a_w * b_z;
            prod_reg[qmn_pkg::LANE_Z][1] <= b_w * a_z;
            prod_reg[qmn_pkg::LANE_Z][2] <= a_x * b_y;
            prod_reg[qmn_pkg::LANE_Z][3] <= a_y * b_x;
            prod_reg[qmn_pkg::LANE_W][0] <= a_w * b_w;
            prod_reg[qmn_pkg::LANE_W][1] <= a_x * b_x;
            prod_reg[qmn_pkg::LANE_W][2] <= a_y * b_y;
            prod_reg[qmn_pkg::LANE_W][3] <= a_z * b_z;
        end
    end

    // ---------------- stage 1: component sums ----------------
    logic signed [QW-1:0] q_reg  [NL];
    logic signed [QW-1:0] q_next [NL];

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            if (l == qmn_pkg::LANE_W)
            begin
                q_next[l] = QW'(prod_reg[l][0]) - QW'(prod_reg[l][1])
                          - QW'(prod_reg[l][2]) - QW'(prod_reg[l][3]);
            end
            else
            begin
                q_next[l] = QW'(prod_reg[l][0]) + QW'(prod_reg[l][1])
                          + QW'(prod_reg[l][2]) - QW'(prod_reg[l][3]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            q_reg <= q_next;
        end
    end

    // ---------------- stage 2: sign and magnitude ----------------
    logic [MW-1:0] mag_reg  [NL];
    logic [NL-1:0] neg2_reg;
    logic [QW-1:0] qabs     [NL];

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            qabs[l] = q_reg[l][QW-1] ? -q_reg[l] : q_reg[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MAG])
        begin
            for (int l = 0; l < NL; l++)
            begin
                mag_reg[l]  <= qabs[l][MW-1:0];
                neg2_reg[l] <= q_reg[l][QW-1];
            end
        end
    end

    // ---------------- stage 3: split squaring ----------------
    logic [2*HI-1:0]  hh_reg [NL];
    logic [HI+LO-1:0] hl_reg [NL];
    logic [2*LO-1:0]  ll_reg [NL];
    logic [NL-1:0]    neg3_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_PART])
        begin
            for (int l = 0; l < NL; l++)
            begin
                hh_reg[l] <= (2*HI)'(mag_reg[l][MW-1:LO]) * (2*HI)'(mag_reg[l][MW-1:LO]);
                hl_reg[l] <= (HI+LO)'(mag_reg[l][MW-1:LO]) * (HI+LO)'(mag_reg[l][LO-1:0]);
                ll_reg[l] <= (2*LO)'(mag_reg[l][LO-1:0]) * (2*LO)'(mag_reg[l][LO-1:0]);
            end
            neg3_reg <= neg2_reg;
        end
    end

    // ---------------- stage 4: squares ----------------
    logic [SW-1:0] sq_reg [NL];
    logic [NL-1:0] neg4_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_SQ])
        begin
            for (int l = 0; l < NL; l++)
            begin
                sq_reg[l] <= (SW'(hh_reg[l]) << (2 * LO)) + (SW'(hl_reg[l]) << (LO + 1))
                           + SW'(ll_reg[l]);
            end
            neg4_reg <= neg3_reg;
        end
    end

    // ---------------- stage 5: squared length ----------------
    logic [SW-1:0]  sq5_reg [NL];
    logic [L2W-1:0] l2_reg;
    logic [NL-1:0]  neg5_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_LEN])
        begin
            l2_reg   <= L2W'(sq_reg[0]) + L2W'(sq_reg[1]) + L2W'(sq_reg[2])
                      + L2W'(sq_reg[3]);
            sq5_reg  <= sq_reg;
            neg5_reg <= neg4_reg;
        end
    end

    // ---------------- divide pipeline ----------------
    // Slot j holds the state after j result bits; slot 0 is the setup stage.
    // r = 4*q^2*2^(2F) - d^2*L2, y = d*L2, with d = 2n-1.
    logic signed [RW-1:0]  it_r_reg    [NIT+1][NL];
    logic signed [YW-1:0]  it_y_reg    [NIT+1][NL];
    logic [NW-1:0]         it_n_reg    [NIT+1][NL];
    logic [NL-1:0]         it_neg_reg  [NIT+1];
    logic                  it_zero_reg [NIT+1];
    logic [L2W-1:0]        it_l2_reg   [NIT+1];

    always_ff @(posedge clk)
    begin
        if (en[ST_INIT])
        begin
            for (int l = 0; l < NL; l++)
            begin
                it_r_reg[0][l] <= $signed(RW'(sq5_reg[l]) << (2 * W - 2))
                                - $signed(RW'(l2_reg));
                it_y_reg[0][l] <= -$signed(YW'(l2_reg));
                it_n_reg[0][l] <= '0;
            end
            it_neg_reg[0]  <= neg5_reg;
            it_zero_reg[0] <= (l2_reg == '0);
            it_l2_reg[0]   <= l2_reg;
        end
    end

    for (genvar i = 0; i < NIT; i++)
    begin : g_div
        localparam int B = F - i;

        logic signed [RW-1:0] delta [NL];
        logic signed [RW-1:0] diff  [NL];
        logic signed [RW-1:0] l2s;

        always_comb
        begin
            l2s = $signed(RW'(it_l2_reg[i]));
            for (int l = 0; l < NL; l++)
            begin
                delta[l] = (RW'(it_y_reg[i][l]) + (l2s <<< B)) <<< (B + 2);
                diff[l]  = it_r_reg[i][l] - delta[l];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_INIT + i + 1])
            begin
                for (int l = 0; l < NL; l++)
                begin
                    if (!diff[l][RW-1])
                    begin
                        it_r_reg[i+1][l] <= diff[l];
                        it_y_reg[i+1][l] <= it_y_reg[i][l]
                                          + $signed(YW'(it_l2_reg[i]) << (B + 1));
                        it_n_reg[i+1][l] <= it_n_reg[i][l] | (NW'(1) << B);
                    end
                    else
                    begin
                        it_r_reg[i+1][l] <= it_r_reg[i][l];
                        it_y_reg[i+1][l] <= it_y_reg[i][l];
                        it_n_reg[i+1][l] <= it_n_reg[i][l];
                    end
                end
                it_neg_reg[i+1]  <= it_neg_reg[i];
                it_zero_reg[i+1] <= it_zero_reg[i];
                it_l2_reg[i+1]   <= it_l2_reg[i];
            end
        end
    end

    // ---------------- output stage ----------------
    logic signed [W-1:0] p_reg  [NL];
    logic signed [W-1:0] p_next [NL];
    logic                zero_length_reg;

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            if (it_zero_reg[NIT])
            begin
                p_next[l] = '0;
            end
            else if (it_neg_reg[NIT][l])
            begin
                p_next[l] = -$signed(W'(it_n_reg[NIT][l]));
            end
            else
            begin
                p_next[l] = $signed(W'(it_n_reg[NIT][l]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            p_reg           <= p_next;
            zero_length_reg <= it_zero_reg[NIT];
        end
    end

    assign p_x         = p_reg[qmn_pkg::LANE_X];
    assign p_y         = p_reg[qmn_pkg::LANE_Y];
    assign p_z         = p_reg[qmn_pkg::LANE_Z];
    assign p_w         = p_reg[qmn_pkg::LANE_W];
    assign zero_length = zero_length_reg;

    // ---------------- checks ----------------
    `ASSERT_NEXT(a_accept_lands, clk, rst_n, in_valid && in_ready, v_reg[ST_PROD])
    `ASSERT_IMP(a_full_only_on_stall, clk, rst_n, !in_ready, out_valid && !out_ready)
    `ASSERT_IMP(a_zero_forces_zero, clk, rst_n, out_valid && zero_length,
        p_x == '0 && p_y == '0 && p_z == '0 && p_w == '0)
    `ASSERT_IMP(a_unit_not_zero, clk, rst_n, out_valid && !zero_length,
        (p_x | p_y | p_z | p_w) != '0)

endmodule
